[rtl/csc_pkg.sv]
`default_nettype none

package csc_pkg;

    localparam int WORD_W          = 32;
    localparam int ADD_W           = WORD_W + 2;
    localparam int STEP_W          = $clog2(WORD_W);
    localparam int KIND_W          = 3;
    localparam int STATUS_W        = 3;
    localparam int DEPTH_W         = 5;
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUB  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MUL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DIV  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_NEG_ONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [WORD_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
    } out_t;

endpackage

`default_nettype wire

[rtl/csc_ram.sv]
`default_nettype none

module csc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/checked_stack_calculator.sv]
// Path from request accept to result: push or underflow go straight to the result stage;
// unused kind or full-stack push fetch the top word; add/subtract read both operands first;
// multiply and divide iterate one bit per cycle through the shared 34-bit adder, but divide
// by zero or INT_MIN / -1 skip the iteration. Requests are taken one at a time; the next is
// taken the cycle after the result is registered, and later while the result is held.
// Reset (aresetn low, synchronous): stack empty, no result pending, sequencer idle.
`default_nettype none

module checked_stack_calculator #(
    parameter int STACK_DEPTH = csc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire csc_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output csc_pkg::out_t      m_data
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int EXT_W = CW + csc_pkg::DEPTH_W;
    localparam int W     = csc_pkg::WORD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_L, S_RD_WAIT, S_ALU, S_MUL, S_DIV,
        S_FIX, S_PUSH, S_FETCH, S_TOPW, S_OUT
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [csc_pkg::KIND_W-1:0]      kind_reg, kind_next;
    logic [csc_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [W-1:0]                    top_reg, top_next;
    logic [W-1:0]                    r_reg, r_next;
    logic [W-1:0]                    rmag_reg, rmag_next;
    logic [W-1:0]                    lmag_reg, lmag_next;
    logic [W-1:0]                    result_reg, result_next;
    logic [2*W-1:0]                  p_reg, p_next;
    logic [csc_pkg::STEP_W-1:0]      step_reg, step_next;
    logic                            neg_reg, neg_next;
    logic                            m_valid_reg, m_valid_next;
    csc_pkg::out_t                   m_data_reg, m_data_next;

    logic [csc_pkg::ADD_W-1:0]       add_a, add_b, add_sum;
    logic                            add_sub;

    logic                            wr_en, rd_en;
    logic [AW-1:0]                   wr_addr, rd_addr;
    logic [W-1:0]                    wr_data, rd_data;

    logic [CW-1:0]                   cnt_m1, cnt_m2;
    logic [EXT_W-1:0]                cnt_ext;
    logic                            accept, out_load, mul_ovf, step_last, div_ge;
    logic [W-1:0]                    div_rem;

    csc_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared add/subtract unit
    assign add_sum = add_a + (add_b ^ {csc_pkg::ADD_W{add_sub}})
                   + csc_pkg::ADD_W'(add_sub);

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);
    assign cnt_m1    = count_reg - CW'(1);
    assign cnt_m2    = count_reg - CW'(2);
    assign cnt_ext   = EXT_W'(count_reg);
    assign step_last = (step_reg == csc_pkg::STEP_W'(W - 1));
    assign div_ge    = !add_sum[csc_pkg::ADD_W-1];
    assign div_rem   = div_ge ? add_sum[W-1:0] : {p_reg[2*W-2:W], p_reg[W-1]};
    assign mul_ovf   = neg_reg
        ? ((p_reg[2*W-1:W] != '0) || (p_reg[W-1] && (p_reg[W-2:0] != '0)))
        : (p_reg[2*W-1:W-1] != '0);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        kind_next    = kind_reg;
        status_next  = status_reg;
        top_next     = top_reg;
        r_next       = r_reg;
        rmag_next    = rmag_reg;
        lmag_next    = lmag_reg;
        result_next  = result_reg;
        p_next       = p_reg;
        step_next    = step_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        add_a        = '0;
        add_b        = '0;
        add_sub      = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = count_reg[AW-1:0];
        wr_data      = result_reg;
        rd_en        = 1'b0;
        rd_addr      = cnt_m1[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    kind_next   = s_data.kind;
                    status_next = csc_pkg::ST_OK;
                    if (s_data.kind == csc_pkg::KIND_PUSH) begin
                        if (count_reg >= CW'(STACK_DEPTH)) begin
                            status_next = csc_pkg::ST_FULL;
                            state_next  = S_FETCH;
                        end else begin
                            wr_en      = 1'b1;
                            wr_data    = s_data.value;
                            count_next = count_reg + CW'(1);
                            top_next   = s_data.value;
                            state_next = S_OUT;
                        end
                    end else if (s_data.kind <= csc_pkg::KIND_DIV) begin
                        if (count_reg < CW'(2)) begin
                            status_next = csc_pkg::ST_UNDERFLOW;
                            count_next  = '0;
                            top_next    = '0;
                            state_next  = S_OUT;
                        end else begin
                            rd_en      = 1'b1;
                            state_next = S_RD_L;
                        end
                    end else begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_RD_L: begin
                add_b      = {{2{rd_data[W-1]}}, rd_data};
                add_sub    = rd_data[W-1];
                r_next     = rd_data;
                rmag_next  = add_sum[W-1:0];
                rd_en      = 1'b1;
                rd_addr    = cnt_m2[AW-1:0];
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                add_b      = {{2{rd_data[W-1]}}, rd_data};
                add_sub    = rd_data[W-1];
                lmag_next  = add_sum[W-1:0];
                result_next = rd_data;
                count_next = cnt_m2;
                neg_next   = rd_data[W-1] ^ r_reg[W-1];
                step_next  = '0;
                priority case (kind_reg)
                    csc_pkg::KIND_MUL: begin
                        p_next     = {{W{1'b0}}, rmag_reg};
                        state_next = S_MUL;
                    end
                    csc_pkg::KIND_DIV: begin
                        p_next = {{W{1'b0}}, add_sum[W-1:0]};
                        if (r_reg == '0) begin
                            status_next = csc_pkg::ST_DIVZERO;
                            state_next  = S_FETCH;
                        end else if (rd_data == csc_pkg::WORD_MIN
                                     && r_reg == csc_pkg::WORD_NEG_ONE) begin
                            status_next = csc_pkg::ST_OVERFLOW;
                            state_next  = S_FETCH;
                        end else begin
                            state_next = S_DIV;
                        end
                    end
                    default: begin
                        state_next = S_ALU;
                    end
                endcase
            end
            S_ALU: begin
                add_a   = {{2{result_reg[W-1]}}, result_reg};
                add_b   = {{2{r_reg[W-1]}}, r_reg};
                add_sub = (kind_reg == csc_pkg::KIND_SUB);
                if (add_sum[W] != add_sum[W-1]) begin
                    status_next = csc_pkg::ST_OVERFLOW;
                    state_next  = S_FETCH;
                end else begin
                    result_next = add_sum[W-1:0];
                    state_next  = S_PUSH;
                end
            end
            S_MUL: begin
                add_a     = {2'b00, p_reg[2*W-1:W]};
                add_b     = p_reg[0] ? {2'b00, lmag_reg} : '0;
                p_next    = {add_sum[W:0], p_reg[W-1:1]};
                step_next = step_reg + csc_pkg::STEP_W'(1);
                if (step_last) begin
                    state_next = S_FIX;
                end
            end
            S_DIV: begin
                add_a     = {1'b0, p_reg[2*W-1:W], p_reg[W-1]};
                add_b     = {2'b00, rmag_reg};
                add_sub   = 1'b1;
                p_next    = {div_rem, p_reg[W-2:0], div_ge};
                step_next = step_reg + csc_pkg::STEP_W'(1);
                if (step_last) begin
                    state_next = S_FIX;
                end
            end
            S_FIX: begin
                add_b   = {2'b00, p_reg[W-1:0]};
                add_sub = neg_reg;
                if (kind_reg == csc_pkg::KIND_MUL && mul_ovf) begin
                    status_next = csc_pkg::ST_OVERFLOW;
                    state_next  = S_FETCH;
                end else begin
                    result_next = add_sum[W-1:0];
                    state_next  = S_PUSH;
                end
            end
            S_PUSH: begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                top_next   = result_reg;
                state_next = S_OUT;
            end
            S_FETCH: begin
                if (count_reg == '0) begin
                    top_next   = '0;
                    state_next = S_OUT;
                end else begin
                    rd_en      = 1'b1;
                    state_next = S_TOPW;
                end
            end
            S_TOPW: begin
                top_next   = rd_data;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    m_valid_next          = 1'b1;
                    m_data_next.status    = status_reg;
                    m_data_next.top_value = top_reg;
                    m_data_next.depth     = cnt_ext[csc_pkg::DEPTH_W-1:0];
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg   <= kind_next;
        status_reg <= status_next;
        top_reg    <= top_next;
        r_reg      <= r_next;
        rmag_reg   <= rmag_next;
        lmag_reg   <= lmag_next;
        result_reg <= result_next;
        p_reg      <= p_next;
        step_reg   <= step_next;
        neg_reg    <= neg_next;
        m_data_reg <= m_data_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> count_reg < CW'(STACK_DEPTH))
        else $error("write into full stack");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && status_reg == csc_pkg::ST_FULL) |-> count_reg == CW'(STACK_DEPTH))
        else $error("full reported on non-full stack");

    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && status_reg == csc_pkg::ST_UNDERFLOW) |-> count_reg == '0)
        else $error("underflow left words on stack");

    a_iter_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL || state_reg == S_DIV) |=>
            (state_reg == S_MUL || state_reg == S_DIV || state_reg == S_FIX))
        else $error("iteration left early");

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int STACK_DEPTH = csc_pkg::STACK_DEPTH_DEF;
    localparam logic [csc_pkg::KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [csc_pkg::KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;
    localparam int DRAIN_CYCLES = 45;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    csc_pkg::in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    csc_pkg::out_t m_data;

    checked_stack_calculator u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // software copy of the operand stack
    logic signed [csc_pkg::WORD_W-1:0] calc_words [STACK_DEPTH];
    int   calc_count = 0;
    csc_pkg::out_t rpn_results_due[$];

    bit sender_idle   = 1'b0;
    bit receiver_idle = 1'b0;
    int hold_request  = 0;

    int requests_sent   = 0;
    int push_count      = 0;
    int op_count        = 0;
    int unused_count    = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int error_count     = 0;
    int status_seen [8];

    function automatic csc_pkg::out_t rpn_step(csc_pkg::in_t req);
        csc_pkg::out_t res;
        longint lhs;
        longint rhs;
        longint full;
        logic signed [csc_pkg::WORD_W-1:0] narrow;
        res.status = csc_pkg::ST_OK;
        if (req.kind == csc_pkg::KIND_PUSH) begin
            if (calc_count < STACK_DEPTH) begin
                calc_words[calc_count] = req.value;
                calc_count++;
            end else begin
                res.status = csc_pkg::ST_FULL;
            end
        end else if (req.kind <= csc_pkg::KIND_DIV) begin
            if (calc_count < 2) begin
                calc_count = 0;
                res.status = csc_pkg::ST_UNDERFLOW;
            end else begin
                rhs = calc_words[calc_count - 1];
                lhs = calc_words[calc_count - 2];
                calc_count -= 2;
                full = 0;
                case (req.kind)
                    csc_pkg::KIND_ADD: full = lhs + rhs;
                    csc_pkg::KIND_SUB: full = lhs - rhs;
                    csc_pkg::KIND_MUL: full = lhs * rhs;
                    default: begin
                        if (rhs == 0)
                            res.status = csc_pkg::ST_DIVZERO;
                        else if (lhs == longint'($signed(csc_pkg::WORD_MIN)) && rhs == -1)
                            res.status = csc_pkg::ST_OVERFLOW;
                        else
                            full = lhs / rhs;
                    end
                endcase
                narrow = full[csc_pkg::WORD_W-1:0];
                if (res.status == csc_pkg::ST_OK && longint'(narrow) != full)
                    res.status = csc_pkg::ST_OVERFLOW;
                if (res.status == csc_pkg::ST_OK) begin
                    calc_words[calc_count] = narrow;
                    calc_count++;
                end
            end
        end
        res.top_value = (calc_count > 0) ? calc_words[calc_count - 1] : '0;
        res.depth     = calc_count[csc_pkg::DEPTH_W-1:0];
        return res;
    endfunction

    function automatic logic signed [csc_pkg::WORD_W-1:0] random_word();
        logic signed [15:0] half;
        half = 16'($urandom);
        case ($urandom_range(0, 7))
            0: return csc_pkg::WORD_MIN;
            1: return ~csc_pkg::WORD_MIN;
            2: return csc_pkg::WORD_NEG_ONE;
            3: return '0;
            4: return csc_pkg::WORD_W'($urandom_range(0, 40)) - 20;
            5: return half;
            default: return $urandom;
        endcase
    endfunction

    function automatic csc_pkg::in_t random_request();
        csc_pkg::in_t req;
        int  pick;
        pick      = $urandom_range(0, 99);
        req.value = random_word();
        if (pick < 4)
            req.kind = csc_pkg::KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
        else if (calc_count < 2 && pick < 94)
            req.kind = csc_pkg::KIND_PUSH;
        else if (calc_count >= STACK_DEPTH && pick < 70)
            req.kind = csc_pkg::KIND_W'($urandom_range(csc_pkg::KIND_ADD, csc_pkg::KIND_DIV));
        else if (pick < 52)
            req.kind = csc_pkg::KIND_PUSH;
        else
            req.kind = csc_pkg::KIND_W'($urandom_range(csc_pkg::KIND_ADD, csc_pkg::KIND_DIV));
        return req;
    endfunction

    // valid is left high on return so back-to-back requests need no extra edge
    task automatic send_request(input logic [csc_pkg::KIND_W-1:0] kind,
                                input logic signed [csc_pkg::WORD_W-1:0] value);
        csc_pkg::in_t req;
        req.kind  = kind;
        req.value = value;
        if (sender_idle && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        rpn_results_due.push_back(rpn_step(req));
        requests_sent++;
        if (kind == csc_pkg::KIND_PUSH)
            push_count++;
        else if (kind <= csc_pkg::KIND_DIV)
            op_count++;
        else
            unused_count++;
    endtask

    task automatic send_random();
        csc_pkg::in_t req;
        req = random_request();
        send_request(req.kind, req.value);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (rpn_results_due.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        csc_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rpn_results_due.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: status %0d top %0d depth %0d",
                             m_data.status, m_data.top_value, m_data.depth);
            end else begin
                want = rpn_results_due.pop_front();
                results_checked++;
                status_seen[want.status]++;
                if (m_data.status != want.status || m_data.top_value != want.top_value
                        || m_data.depth != want.depth) begin
                    mismatch_count++;
                    error_count++;
                    if (error_count <= 10)
                        $display({"result %0d mismatch: exp status %0d top %0d depth %0d,",
                                  " got status %0d top %0d depth %0d"},
                                 results_checked, want.status, want.top_value, want.depth,
                                 m_data.status, m_data.top_value, m_data.depth);
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                m_ready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
                m_ready <= 1'b1;
            end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        send_request(csc_pkg::KIND_ADD, 32'sd5);
        send_request(csc_pkg::KIND_PUSH, ~csc_pkg::WORD_MIN);
        send_request(csc_pkg::KIND_PUSH, 32'sd1);
        send_request(csc_pkg::KIND_ADD, '0);
        send_request(csc_pkg::KIND_PUSH, 32'sd9);
        send_request(csc_pkg::KIND_SUB, '0);
        send_request(csc_pkg::KIND_PUSH, csc_pkg::WORD_MIN);
        send_request(csc_pkg::KIND_PUSH, 32'sd1);
        send_request(csc_pkg::KIND_SUB, '0);
        send_request(csc_pkg::KIND_PUSH, csc_pkg::WORD_MIN);
        send_request(csc_pkg::KIND_PUSH, csc_pkg::WORD_NEG_ONE);
        send_request(csc_pkg::KIND_DIV, '0);
        send_request(csc_pkg::KIND_PUSH, 32'sd7);
        send_request(csc_pkg::KIND_PUSH, '0);
        send_request(csc_pkg::KIND_DIV, csc_pkg::WORD_NEG_ONE);
        send_request(csc_pkg::KIND_PUSH, csc_pkg::WORD_MIN);
        send_request(csc_pkg::KIND_PUSH, csc_pkg::WORD_NEG_ONE);
        send_request(csc_pkg::KIND_MUL, '0);
        send_request(csc_pkg::KIND_PUSH, -32'sd7);
        send_request(csc_pkg::KIND_PUSH, 32'sd2);
        send_request(csc_pkg::KIND_DIV, '0);
        send_request(csc_pkg::KIND_PUSH, 32'sd3);
        send_request(csc_pkg::KIND_MUL, ~csc_pkg::WORD_MIN);
        for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
            send_request(csc_pkg::KIND_W'(k), random_word());
    endtask

    task automatic test_stack_full();
        while (calc_count < STACK_DEPTH)
            send_request(csc_pkg::KIND_PUSH, random_word());
        send_request(csc_pkg::KIND_PUSH, csc_pkg::WORD_MIN);
        send_request(csc_pkg::KIND_PUSH, ~csc_pkg::WORD_MIN);
        while (calc_count > 1)
            send_request(csc_pkg::KIND_W'($urandom_range(csc_pkg::KIND_ADD, csc_pkg::KIND_SUB)),
                         random_word());
    endtask

    // result side blocked long enough that the input stalls behind it
    task automatic test_backpressure();
        hold_request = 200;
        repeat (12) send_random();
    endtask

    task automatic test_drain_pause();
        repeat (20) send_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        repeat (20) send_random();
    endtask

    task automatic test_random(input int n_items);
        int done;
        done = 0;
        while (done < n_items) begin
            if (done == n_items - 150) begin
                sender_idle   = 1'b0;
                receiver_idle = 1'b0;
            end
            send_random();
            if (s_data.kind <= csc_pkg::KIND_DIV)
                done++;
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        test_stack_full();
        test_backpressure();
        test_drain_pause();
        test_random(650);
        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (rpn_results_due.size() != 0)
            error_count++;
        $display("covered %0d requests: %0d pushes, %0d operations, %0d unused kinds",
                 requests_sent, push_count, op_count, unused_count);
        $display({"%0d results checked; ok %0d, underflow %0d, overflow %0d,",
                  " divide by zero %0d, full %0d; mismatches %0d"},
                 results_checked, status_seen[csc_pkg::ST_OK],
                 status_seen[csc_pkg::ST_UNDERFLOW], status_seen[csc_pkg::ST_OVERFLOW],
                 status_seen[csc_pkg::ST_DIVZERO], status_seen[csc_pkg::ST_FULL],
                 mismatch_count);
        if (error_count == 0)
            $display("[checked_stack_calculator] OK");
        else
            $display("[checked_stack_calculator] ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("[checked_stack_calculator] ERROR");
        $finish;
    end

endmodule
